>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the stencil point update block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define JSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define JSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define JSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/jsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsp_pkg
// Types, register indexes and constants of the 3D Jacobi point update block.
// ----------------------------------------------------------------------------
package jsp_pkg;

    // grid and pipeline shape
    localparam int GRID_SIZE   = 512;
    localparam int AXES        = 3;
    localparam int STAGES      = 12;

    // field widths
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 9;
    localparam int CHG_W       = 31;
    localparam int SQ_W        = 35;
    localparam int PHI_W       = 36;
    localparam int RHO_W       = 62;
    localparam int LAP_W       = 60;
    localparam int NUM_MAG_W   = 61;
    localparam int DEN_W       = 48;

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ORIGIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_SQ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DENOMINATOR = 3'd4;

    // register reset values
    localparam logic [31:0] GRID_ORIGIN_RST     = 32'hF000_0000;
    localparam logic [30:0] GRID_STEP_RST       = 31'd1401753;
    localparam logic [31:0] COEF_A_RST          = 32'd25600000;
    localparam logic [31:0] INV_STEP_SQ_RST     = 32'd9388096;
    localparam logic [47:0] INV_DENOMINATOR_RST = 48'd879517229;

    // 6.0 in Q4.28
    localparam logic [31:0] SIX_Q28 = 32'h6000_0000;

    // saturation limits of Q4.28
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [30:0] CHG_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] center;
        logic signed [31:0] east;
        logic signed [31:0] west;
        logic signed [31:0] north;
        logic signed [31:0] south;
        logic signed [31:0] above;
        logic signed [31:0] below;
        logic [8:0]         col_index;
        logic [8:0]         row_index;
        logic [8:0]         plane_index;
        logic               sweep_end;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] new_value;
        logic [30:0]        change;
        logic [30:0]        sweep_max;
        logic               sweep_done;
    } t_point_out;

    // what travels beside the arithmetic down the pipeline
    typedef struct packed {
        logic [31:0] center;
        logic        interior;
        logic        last;
    } t_side;

endpackage
`default_nettype wire

>>> sv/jsp_coord_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsp_coord_lane
// One axis lane: coordinate from index, saturate to Q4.28, square (Q7.28).
// Three register stages.
// ----------------------------------------------------------------------------
module jsp_coord_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [jsp_pkg::IDX_W-1:0]     i_index,
    input  wire logic [31:0]                   i_origin,
    input  wire logic [30:0]                   i_step,
    output logic      [jsp_pkg::SQ_W-1:0]      o_square
);

    logic [39:0] r_prod;
    logic [31:0] r_mag;
    logic [jsp_pkg::SQ_W-1:0] r_sq;

    logic [39:0] n_prod;
    logic [40:0] w_coord;
    logic        w_pos_ovf;
    logic        w_neg_ovf;
    logic [31:0] w_neg_mag;
    logic [31:0] n_mag;
    logic [63:0] w_sq_full;

    // index times step
    assign n_prod = 40'(i_index) * 40'(i_step);

    // origin plus offset, then saturate and take the magnitude
    always_comb begin
        w_coord   = {{9{i_origin[31]}}, i_origin} + {1'b0, r_prod};
        w_pos_ovf = !w_coord[40] && (w_coord[39:31] != 9'h000);
        w_neg_ovf = w_coord[40] && (w_coord[39:31] != 9'h1FF);
        w_neg_mag = ~w_coord[31:0] + 32'd1;
        if (w_pos_ovf) begin
            n_mag = jsp_pkg::VAL_MAX;
        end else if (w_neg_ovf) begin
            n_mag = jsp_pkg::VAL_MIN;
        end else if (w_coord[40]) begin
            n_mag = w_neg_mag;
        end else begin
            n_mag = w_coord[31:0];
        end
    end

    // square, drop 28 fraction bits
    assign w_sq_full = 64'(r_mag) * 64'(r_mag);

    // advance the lane stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_mag  <= n_mag;
            r_sq   <= w_sq_full[62:28];
        end
    end

    assign o_square = r_sq;

endmodule
`default_nettype wire

>>> sv/jsp_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsp_merge
// Merges the axis lanes: phi = sum of squares, a*phi split in two partial
// products, rho = 6 - a*phi. Three register stages.
// ----------------------------------------------------------------------------
module jsp_merge (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_en,
    input  wire logic [jsp_pkg::AXES-1:0][jsp_pkg::SQ_W-1:0] i_square,
    input  wire logic [31:0]                                i_coef_a,
    output logic      [jsp_pkg::RHO_W-1:0]                  o_rho
);

    logic [jsp_pkg::PHI_W-1:0] r_phi;
    logic [63:0]               r_apl;
    logic [35:0]               r_aph;
    logic [jsp_pkg::RHO_W-1:0] r_rho;

    logic [jsp_pkg::PHI_W-1:0] n_phi;
    logic [67:0]               w_afull;

    // sum the lanes
    always_comb begin
        n_phi = '0;
        for (int k = 0; k < jsp_pkg::AXES; k++) begin
            n_phi = n_phi + jsp_pkg::PHI_W'(i_square[k]);
        end
    end

    // recombine a*phi, drop 8 fraction bits of a
    assign w_afull = 68'(r_apl) + {r_aph, 32'h0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phi <= n_phi;
            r_apl <= 64'(i_coef_a) * 64'(r_phi[31:0]);
            r_aph <= 36'(i_coef_a) * 36'(r_phi[35:32]);
            r_rho <= {30'h0, jsp_pkg::SIX_Q28} - {2'b00, w_afull[67:8]};
        end
    end

    assign o_rho = r_rho;

endmodule
`default_nettype wire

>>> sv/jsp_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsp_scale
// Unsigned 61 x 48 bit product shifted right 48, built from four partial
// products. Gives the low 32 quotient bits and a flag for quotients that do
// not fit. Three register stages.
// ----------------------------------------------------------------------------
module jsp_scale (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [jsp_pkg::NUM_MAG_W-1:0]   i_mag,
    input  wire logic [jsp_pkg::DEN_W-1:0]       i_factor,
    output logic      [31:0]                     o_quot,
    output logic                                 o_big
);

    logic [55:0]  r_ll;
    logic [55:0]  r_lh;
    logic [52:0]  r_hl;
    logic [52:0]  r_hh;
    logic [108:0] r_s1;
    logic [108:0] r_s2;
    logic [31:0]  r_quot;
    logic         r_big;

    logic [108:0] w_prod;

    // final sum of the two halves
    assign w_prod = r_s1 + r_s2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // partial products
            r_ll   <= 56'(i_mag[31:0])  * 56'(i_factor[23:0]);
            r_lh   <= 56'(i_mag[31:0])  * 56'(i_factor[47:24]);
            r_hl   <= 53'(i_mag[60:32]) * 53'(i_factor[23:0]);
            r_hh   <= 53'(i_mag[60:32]) * 53'(i_factor[47:24]);
            // pairwise alignment sums
            r_s1   <= 109'(r_ll) + {29'h0, r_lh, 24'h0};
            r_s2   <= {24'h0, r_hl, 32'h0} + {r_hh, 56'h0};
            // shift out 48 fraction bits
            r_quot <= w_prod[79:48];
            r_big  <= |w_prod[108:80];
        end
    end

    assign o_quot = r_quot;
    assign o_big  = r_big;

endmodule
`default_nettype wire

>>> sv/jacobi_stencil_3d_point_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_stencil_3d_point_update
// One grid point of a 3D Jacobi sweep with a 7-point stencil in Q4.28.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one grid point per
// transaction with its center value, six neighbors, indices and sweep_end.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per
// point: new value, absolute change, running sweep maximum and sweep_done.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
// always ready; write it only while no point is in flight.
// Throughput: one point per cycle while no held result stalls the
// pipeline, which has 12 stages: three axis lanes build the squared
// coordinates, a merge block forms rho, and a four-part multiplier
// applies the inverse denominator.
// A finished result that waits on a stalled receiver holds the whole
// pipeline and drops o_in_ready; the held result keeps its payload. Reset
// empties the pipeline, loads the register defaults and clears the sweep
// maximum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jacobi_stencil_3d_point_update #(
    parameter int GRID_SIZE = jsp_pkg::GRID_SIZE
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // point input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire jsp_pkg::t_point_in                i_in_data,
    // result output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output jsp_pkg::t_point_out                    o_out_data,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [jsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [jsp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LAST = jsp_pkg::STAGES - 1;
    localparam logic [12:0] LAST_IDX = 13'(GRID_SIZE - 1);

    // configuration registers
    logic [31:0] r_grid_origin;
    logic [30:0] r_grid_step;
    logic [31:0] r_coef_a;
    logic [31:0] r_inv_step_sq;
    logic [47:0] r_inv_den;

    // pipeline control
    logic [LAST:0]   r_vld;
    jsp_pkg::t_side  r_side [0:LAST-1];
    logic            w_en;
    logic            w_accept;
    jsp_pkg::t_side  n_side;

    // neighbor path
    logic [34:0]               r_nsum;
    logic [33:0]               r_nmag;
    logic                      r_nneg;
    logic [63:0]               r_lpl;
    logic [33:0]               r_lph;
    logic                      r_lneg;
    logic [jsp_pkg::LAP_W-1:0] r_lap;
    logic [jsp_pkg::LAP_W-1:0] r_lap5;
    logic [jsp_pkg::LAP_W-1:0] r_lap6;

    logic [34:0]               n_nsum;
    logic [34:0]               w_nabs;
    logic [65:0]               w_lfull;
    logic [jsp_pkg::LAP_W-1:0] w_lapext;

    // lanes and merge
    logic [jsp_pkg::AXES-1:0][jsp_pkg::IDX_W-1:0] w_index;
    logic [jsp_pkg::AXES-1:0][jsp_pkg::SQ_W-1:0]  w_square;
    logic [jsp_pkg::RHO_W-1:0]                     w_rho;

    // numerator and scaling
    logic [jsp_pkg::NUM_MAG_W-1:0] r_num_mag;
    logic                          r_num_neg;
    logic                          r_num_neg8;
    logic                          r_num_neg9;
    logic                          r_num_neg10;
    logic [62:0]                   w_num;
    logic [62:0]                   w_num_abs;
    logic [31:0]                   w_quot;
    logic                          w_big;

    // result stage
    logic [31:0] r_result;
    logic [30:0] r_change;
    logic [31:0] n_result;
    logic [32:0] w_diff;
    logic [32:0] w_dmag;
    logic [30:0] n_change;

    // sweep maximum and output
    logic [30:0]          r_max;
    logic [30:0]          w_smax;
    jsp_pkg::t_point_out  r_out;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // advance everything unless a finished result is held
    assign w_en        = !r_vld[LAST] || i_out_ready;
    assign w_accept    = i_in_valid && w_en;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_origin <= jsp_pkg::GRID_ORIGIN_RST;
            r_grid_step   <= jsp_pkg::GRID_STEP_RST;
            r_coef_a      <= jsp_pkg::COEF_A_RST;
            r_inv_step_sq <= jsp_pkg::INV_STEP_SQ_RST;
            r_inv_den     <= jsp_pkg::INV_DENOMINATOR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jsp_pkg::REG_GRID_ORIGIN:     r_grid_origin <= i_cfg_data[31:0];
                jsp_pkg::REG_GRID_STEP:       r_grid_step   <= i_cfg_data[30:0];
                jsp_pkg::REG_COEF_A:          r_coef_a      <= i_cfg_data[31:0];
                jsp_pkg::REG_INV_STEP_SQ:     r_inv_step_sq <= i_cfg_data[31:0];
                jsp_pkg::REG_INV_DENOMINATOR: r_inv_den     <= i_cfg_data[47:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and side data
    // ------------------------------------------------------------------
    // interior when no index is on or beyond a face
    always_comb begin
        n_side.center   = i_in_data.center;
        n_side.last     = i_in_data.sweep_end;
        n_side.interior = (i_in_data.col_index != '0)
                       && (i_in_data.row_index != '0)
                       && (i_in_data.plane_index != '0)
                       && ({4'h0, i_in_data.col_index} < LAST_IDX)
                       && ({4'h0, i_in_data.row_index} < LAST_IDX)
                       && ({4'h0, i_in_data.plane_index} < LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < LAST; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Axis lanes and merge
    // ------------------------------------------------------------------
    assign w_index[0] = i_in_data.col_index;
    assign w_index[1] = i_in_data.row_index;
    assign w_index[2] = i_in_data.plane_index;

    for (genvar g = 0; g < jsp_pkg::AXES; g++) begin : g_lane
        jsp_coord_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_index  (w_index[g]),
            .i_origin (r_grid_origin),
            .i_step   (r_grid_step),
            .o_square (w_square[g])
        );
    end

    jsp_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_square (w_square),
        .i_coef_a (r_coef_a),
        .o_rho    (w_rho)
    );

    // ------------------------------------------------------------------
    // Neighbor sum times one over step squared
    // ------------------------------------------------------------------
    assign n_nsum = {{3{i_in_data.east[31]}},  i_in_data.east}
                  + {{3{i_in_data.west[31]}},  i_in_data.west}
                  + {{3{i_in_data.north[31]}}, i_in_data.north}
                  + {{3{i_in_data.south[31]}}, i_in_data.south}
                  + {{3{i_in_data.above[31]}}, i_in_data.above}
                  + {{3{i_in_data.below[31]}}, i_in_data.below};

    assign w_nabs   = ~r_nsum + 35'd1;
    assign w_lfull  = 66'(r_lpl) + {r_lph, 32'h0};
    assign w_lapext = {2'b00, w_lfull[65:8]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nsum <= n_nsum;
            r_nneg <= r_nsum[34];
            r_nmag <= r_nsum[34] ? w_nabs[33:0] : r_nsum[33:0];
            r_lpl  <= 64'(r_nmag[31:0]) * 64'(r_inv_step_sq);
            r_lph  <= 34'(r_nmag[33:32]) * 34'(r_inv_step_sq);
            r_lneg <= r_nneg;
            // restore the sign, truncating toward zero
            r_lap  <= r_lneg ? (~w_lapext + 60'd1) : w_lapext;
            r_lap5 <= r_lap;
            r_lap6 <= r_lap5;
        end
    end

    // ------------------------------------------------------------------
    // Numerator and scaling by the inverse denominator
    // ------------------------------------------------------------------
    assign w_num     = {{3{r_lap6[59]}}, r_lap6} - {w_rho[61], w_rho};
    assign w_num_abs = ~w_num + 63'd1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num_neg   <= w_num[62];
            r_num_mag   <= w_num[62] ? w_num_abs[60:0] : w_num[60:0];
            r_num_neg8  <= r_num_neg;
            r_num_neg9  <= r_num_neg8;
            r_num_neg10 <= r_num_neg9;
        end
    end

    jsp_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_mag    (r_num_mag),
        .i_factor (r_inv_den),
        .o_quot   (w_quot),
        .o_big    (w_big)
    );

    // ------------------------------------------------------------------
    // Saturate, select boundary pass-through, absolute change
    // ------------------------------------------------------------------
    always_comb begin
        if (!r_side[9].interior) begin
            n_result = r_side[9].center;
        end else if (w_big || w_quot[31]) begin
            n_result = r_num_neg10 ? jsp_pkg::VAL_MIN : jsp_pkg::VAL_MAX;
        end else if (r_num_neg10) begin
            n_result = ~w_quot + 32'd1;
        end else begin
            n_result = w_quot;
        end
        w_diff   = {n_result[31], n_result} - {r_side[9].center[31], r_side[9].center};
        w_dmag   = w_diff[32] ? (~w_diff + 33'd1) : w_diff;
        n_change = (w_dmag[32:31] != 2'b00) ? jsp_pkg::CHG_MAX : w_dmag[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_result <= n_result;
            r_change <= n_change;
        end
    end

    // ------------------------------------------------------------------
    // Sweep maximum and output register
    // ------------------------------------------------------------------
    assign w_smax = (r_change > r_max) ? r_change : r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (w_en && r_vld[LAST-1]) begin
            r_max <= r_side[LAST-1].last ? '0 : w_smax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.new_value  <= r_result;
            r_out.change     <= r_change;
            r_out.sweep_max  <= w_smax;
            r_out.sweep_done <= r_side[LAST-1].last;
        end
    end

    assign o_out_valid = r_vld[LAST];
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `JSP_ASSERT_IMPL(a_max_covers_change, i_clk, i_rst_n, o_out_valid,
        o_out_data.sweep_max >= o_out_data.change, "sweep maximum below point change")
    `JSP_ASSERT_NEXT(a_max_cleared, i_clk, i_rst_n,
        w_en && r_vld[LAST-1] && r_side[LAST-1].last, r_max == '0,
        "sweep maximum not cleared at sweep end")
    `JSP_ASSERT_IMPL(a_boundary_pass, i_clk, i_rst_n,
        r_vld[LAST-1] && !r_side[LAST-1].interior,
        (r_change == '0) && (r_result == r_side[LAST-1].center), "boundary point changed")

endmodule
`default_nettype wire
